### sv/itra_pkg.sv
// Shared constants, command/status types and character mapping for the radix text block.
package itra_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int RADIX_W           = 6;
    localparam int CHAR_W            = 7;
    localparam int BITS_PER_CYCLE    = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h61;
    localparam logic [CHAR_W-1:0] DIGITS_DEC = 7'd10;

    typedef struct packed {
        logic load;
        logic div_step;
        logic out_minus;
        logic pop;
        logic out_digit;
    } itra_cmd_t;

    typedef struct packed {
        logic div_done;
        logic quot_zero;
        logic neg;
        logic stack_empty;
        logic out_free;
    } itra_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (dx < DIGITS_DEC) begin
            return dx + CHAR_ZERO;
        end
        return dx + (CHAR_ALPHA - DIGITS_DEC);
    endfunction

endpackage

### sv/integer_to_radix_ascii_core.sv
// Top level: signed integer to ASCII text in a programmable radix (2..36).
//
// s_tdata carries one WORD_BITS-bit two's complement value per request.
// m_tdata carries one ASCII character per transfer, most significant first;
// m_tlast marks the final character. Digits are 0-9 then a-z. In radix 10 a
// negative value is preceded by '-'; other radices treat the value as unsigned.
// cfg_data writes the radix (reset 10), clamped into 2..36; write it only idle.
// Per request: an accept step, the digit loop in the shared divider, then a
// pop and an output step per character through the single-port digit stack,
// plus an output step for a sign ahead of the digits.
// A new value is taken once the last character sits in the output register.
// Reset clears the sequencer and output valid and sets the radix to 10.
// A stall on m_tready holds the current character and pauses the unload.
module integer_to_radix_ascii_core #(
    parameter int WORD_BITS = itra_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((WORD_BITS+7)/8)*8-1:0]       s_tdata,  // value
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [itra_pkg::RADIX_W-1:0]         cfg_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,  // text_char, zero pad
    output logic                                 m_tlast
);
    import itra_pkg::*;

    itra_cmd_t         cmd;
    itra_sts_t         sts;
    logic [CHAR_W-1:0] m_char;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, m_char};

    itra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itra_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_value   (s_tdata[WORD_BITS-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_char    (m_char),
        .m_tlast   (m_tlast)
    );

endmodule

### sv/itra_ctrl.sv
// Sequencer: accepts a request, runs the digit loop, then unloads sign and digits.
module itra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  itra_pkg::itra_sts_t sts,
    output itra_pkg::itra_cmd_t cmd
);
    import itra_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MINUS = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done && sts.quot_zero) begin
                    state_next = sts.neg ? ST_MINUS : ST_READ;
                end
            end
            ST_MINUS: begin
                if (sts.out_free) begin
                    cmd.out_minus = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.pop    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_digit = 1'b1;
                    state_next    = sts.stack_empty ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/itra_datapath.sv
// Radix register, 8-bit-per-cycle divider, digit stack and output register.
module itra_datapath #(
    parameter int WORD_BITS = itra_pkg::WORD_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  itra_pkg::itra_cmd_t           cmd,
    output itra_pkg::itra_sts_t           sts,
    input  logic [WORD_BITS-1:0]          s_value,
    input  logic                          cfg_valid,
    input  logic [itra_pkg::RADIX_W-1:0]  cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itra_pkg::CHAR_W-1:0]   m_char,
    output logic                          m_tlast
);
    import itra_pkg::*;

    localparam int STEP_CYC = (WORD_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W    = STEP_CYC * BITS_PER_CYCLE;
    localparam int CNT_W    = $clog2(STEP_CYC + 1);
    localparam int ADDR_W   = $clog2(WORD_BITS);
    localparam int SP_W     = $clog2(WORD_BITS + 1);

    logic [RADIX_W-1:0] radix_reg;
    logic [PAD_W-1:0]   work_reg;
    logic [RADIX_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [RADIX_W-1:0] rd_reg;
    logic               m_tvalid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [RADIX_W-1:0] stack_mem [WORD_BITS];

    logic [PAD_W-1:0]     work_next;
    logic [RADIX_W:0]     rem_next;
    logic                 in_neg;
    logic [WORD_BITS-1:0] in_mag;
    logic                 out_free;
    logic                 div_done;

    assign in_neg   = (radix_reg == RADIX_DEC) && s_value[WORD_BITS-1];
    assign in_mag   = in_neg ? (~s_value + 1'b1) : s_value;
    assign out_free = !m_tvalid_reg || m_tready;
    assign div_done = (cnt_reg == CNT_W'(STEP_CYC - 1));

    // restoring division, BITS_PER_CYCLE quotient bits per cycle
    always_comb begin
        rem_next  = {1'b0, rem_reg};
        work_next = work_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++) begin
            rem_next  = {rem_next[RADIX_W-1:0], work_next[PAD_W-1]};
            work_next = {work_next[PAD_W-2:0], 1'b0};
            if (rem_next >= {1'b0, radix_reg}) begin
                rem_next     = rem_next - {1'b0, radix_reg};
                work_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            if (cfg_data < RADIX_MIN) begin
                radix_reg <= RADIX_MIN;
            end else if (cfg_data > RADIX_MAX) begin
                radix_reg <= RADIX_MAX;
            end else begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sp_reg  <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
            sp_reg  <= '0;
        end else if (cmd.div_step) begin
            if (div_done) begin
                cnt_reg <= '0;
                sp_reg  <= sp_reg + 1'b1;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end else if (cmd.pop) begin
            sp_reg <= sp_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            work_reg <= PAD_W'(in_mag);
            rem_reg  <= '0;
            neg_reg  <= in_neg;
        end else if (cmd.div_step) begin
            work_reg <= work_next;
            rem_reg  <= div_done ? '0 : rem_next[RADIX_W-1:0];
        end
    end

    // digit stack: pushed least significant first, popped most significant first
    always_ff @(posedge aclk) begin
        if (cmd.div_step && div_done) begin
            stack_mem[sp_reg[ADDR_W-1:0]] <= rem_next[RADIX_W-1:0];
        end
        if (cmd.pop) begin
            rd_reg <= stack_mem[ADDR_W'(sp_reg - 1'b1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_minus || cmd.out_digit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_minus) begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.out_digit) begin
            char_reg <= digit_char(rd_reg);
            last_reg <= (sp_reg == '0);
        end
    end

    assign sts.div_done    = div_done;
    assign sts.quot_zero   = (work_next == '0);
    assign sts.neg         = neg_reg;
    assign sts.stack_empty = (sp_reg == '0);
    assign sts.out_free    = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_char   = char_reg;
    assign m_tlast  = last_reg;

endmodule

### sv/itra_checker.sv
// Port-level assertions for the radix text block, bound to the top level.
module itra_checker #(
    parameter int WORD_BITS = itra_pkg::WORD_BITS_DEFAULT
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [((WORD_BITS+7)/8)*8-1:0]   s_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [itra_pkg::RADIX_W-1:0]     cfg_data,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [7:0]                       m_tdata,
    input logic                             m_tlast
);

    // reset clears the output valid
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // one conversion at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while converting");

    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'h2d && !m_tlast)
                  || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
                  || (m_tdata >= 8'h61 && m_tdata <= 8'h7a))
        else $error("bad output character");

endmodule

bind integer_to_radix_ascii_core itra_checker #(.WORD_BITS(WORD_BITS)) u_itra_checker (.*);
